>>> design/spq_pkg.sv
package spq_pkg;

    // Default capacity of the queue
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths
    localparam int ID_W   = 16;
    localparam int SEV_W  = 2;
    localparam int OCC_W  = 5;
    localparam int NUM_SEV = 4;

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // Action codes carried on s_tuser
    typedef enum logic [0:0] {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } action_t;

    // Result status codes carried on m_tuser
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_RESP = 2'd2
    } fsm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Both flags give 3, impact only 2, likelihood only 1, neither 0
    function automatic logic [SEV_W-1:0] sev_of(input logic impact, input logic likely);
        return {impact, likely};
    endfunction

endpackage

>>> design/spq_ram.sv
module spq_ram
    import spq_pkg::*;
#(
    parameter int WIDTH = ID_W,
    parameter int DEPTH = NUM_SEV * QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/spq_ctrl.sv
module spq_ctrl
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                state_next = FSM_RESP;
            end
            FSM_RESP:
            begin
                if (dp_status.out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            FSM_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            FSM_RESP:
            begin
                cmd.load_out = dp_status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/spq_datapath.sv
module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output dp_status_t           dp_status
);

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_SEV * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    // Captured item
    logic             action_reg;
    logic [ID_W-1:0]  id_reg;
    logic             impact_reg;
    logic             likely_reg;

    // One FIFO per severity in a shared RAM
    logic [PTR_W-1:0] head_reg    [NUM_SEV];
    logic [PTR_W-1:0] head_next   [NUM_SEV];
    logic [PTR_W-1:0] tail_reg    [NUM_SEV];
    logic [PTR_W-1:0] tail_next   [NUM_SEV];
    logic [CNT_W-1:0] sev_cnt_reg [NUM_SEV];
    logic [CNT_W-1:0] sev_cnt_next[NUM_SEV];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Result held between execute and output load
    status_t          res_status_reg;
    logic [SEV_W-1:0] res_sev_reg;
    logic             res_hit_reg;

    // Output register
    logic             m_tvalid_reg;
    status_t          out_status_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic [SEV_W-1:0] out_sev_reg;
    logic [OCC_W-1:0] out_occ_reg;

    logic [SEV_W-1:0] item_sev;
    logic [SEV_W-1:0] top_sev;
    logic             is_deq;
    logic             full;
    logic             empty;
    logic             do_enq;
    logic             do_deq;
    logic             ram_we;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ID_W-1:0]  ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Item capture on accept (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= s_tuser[0];
            id_reg     <= s_tdata[ID_W-1:0];
            impact_reg <= s_tdata[ID_W];
            likely_reg <= s_tdata[ID_W+1];
        end
    end

    assign item_sev = sev_of(impact_reg, likely_reg);
    assign is_deq   = (action_reg == ACT_DEQ);
    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_enq   = cmd.exec && !is_deq && !full;
    assign do_deq   = cmd.exec && is_deq && !empty;

    // Highest nonempty severity
    always_comb
    begin
        top_sev = '0;
        for (int k = 0; k < NUM_SEV; k++)
        begin
            if (sev_cnt_reg[k] != '0)
            begin
                top_sev = SEV_W'(k);
            end
        end
    end

    // RAM address is severity * depth + pointer
    assign ram_we    = do_enq;
    assign ram_re    = do_deq;
    assign ram_waddr = ADDR_W'(item_sev) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_reg[item_sev]);
    assign ram_raddr = ADDR_W'(top_sev) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_reg[top_sev]);

    spq_ram #(
        .WIDTH (ID_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (id_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pointer and count updates
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_enq)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_deq)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        for (int k = 0; k < NUM_SEV; k++)
        begin
            head_next[k]    = head_reg[k];
            tail_next[k]    = tail_reg[k];
            sev_cnt_next[k] = sev_cnt_reg[k];
            if (do_enq && item_sev == SEV_W'(k))
            begin
                tail_next[k]    = ptr_inc(tail_reg[k]);
                sev_cnt_next[k] = sev_cnt_reg[k] + 1'b1;
            end
            if (do_deq && top_sev == SEV_W'(k))
            begin
                head_next[k]    = ptr_inc(head_reg[k]);
                sev_cnt_next[k] = sev_cnt_reg[k] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int k = 0; k < NUM_SEV; k++)
            begin
                head_reg[k]    <= '0;
                tail_reg[k]    <= '0;
                sev_cnt_reg[k] <= '0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            for (int k = 0; k < NUM_SEV; k++)
            begin
                head_reg[k]    <= head_next[k];
                tail_reg[k]    <= tail_next[k];
                sev_cnt_reg[k] <= sev_cnt_next[k];
            end
        end
    end

    // Result of the step
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_hit_reg <= do_deq;
            if (is_deq)
            begin
                res_status_reg <= empty ? ST_EMPTY : ST_DONE;
                res_sev_reg    <= empty ? '0 : top_sev;
            end
            else
            begin
                res_status_reg <= full ? ST_FULL : ST_DONE;
                res_sev_reg    <= item_sev;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload; read data is stable since the execute cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_hit_reg ? ram_rdata : '0;
            out_sev_reg    <= res_sev_reg;
            out_occ_reg    <= OCC_W'(cnt_reg);
        end
    end

    assign m_tvalid           = m_tvalid_reg;
    assign m_tuser            = out_status_reg;
    assign m_tdata            = {1'b0, out_occ_reg, out_sev_reg, out_id_reg};
    assign dp_status.out_free = !m_tvalid_reg || m_tready;

endmodule

>>> design/severity_priority_queue_core.sv
// Severity priority queue core.
// Input stream (s_*): one transaction per command. s_tuser selects enqueue (0)
// or dequeue (1); s_tdata carries the item id, impact and likelihood flags.
// Output stream (m_*): exactly one result transaction per command, with the
// status on m_tuser and id, severity and occupancy after the step on m_tdata.
// Entries sit in four per-severity FIFOs inside one RAM of 4 * QUEUE_DEPTH
// words; a dequeue takes the head of the highest nonempty severity, so equal
// severities leave in arrival order. A full queue drops an enqueue (status 1),
// an empty queue reports status 2 on a dequeue.
// The result is produced by the capture / execute / respond sequence of the
// controller around the registered RAM read; the next command is taken only
// after the controller has returned from the respond state to idle.
// The input is taken while a previous result still waits in the output
// register; a stalled receiver holds the result and, once the next command
// has executed, stops further input until the output register frees up.
// Reset empties the queue at once; no clearing pass is needed.
module severity_priority_queue_core
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // item_id[15:0], impact[16], likelihood[17], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,   // action[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_id[15:0], out_severity[17:16], occupancy[22:18], zero pad
    output logic [M_TUSER_W-1:0] m_tuser    // status[1:0]
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .dp_status (dp_status)
    );

`ifndef SYNTHESIS
    // One command in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is in flight");

    // Empty dequeue reports no id and no severity
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[17:0] == '0))
        else $error("empty dequeue carries a payload");

    // Dropped enqueue reports no id
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[15:0] == '0))
        else $error("dropped enqueue carries an id");

    // Output load only happens into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwrites a pending transaction");
`endif

endmodule
